// File: hw/rtl/imu_vector_lowpass_filter_defines.svh
// ----------------------------------------------------------------------------
// IMU vector low-pass filter assertion macros
// Shared property wrappers for the filter's concurrent checks. Both sample on
// the rising edge of clock and are disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef IMU_VECTOR_LOWPASS_FILTER_DEFINES_SVH
`define IMU_VECTOR_LOWPASS_FILTER_DEFINES_SVH

// same-cycle implication
`define IMUVLF_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define IMUVLF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/imuvlf_pkg.sv
// ----------------------------------------------------------------------------
// imuvlf_pkg
// Widths, constants, codes and shared types of the IMU vector low-pass filter.
// ----------------------------------------------------------------------------
package imuvlf_pkg;

   // sizing
   localparam int unsigned NUM_INSTANCES_DEF = 3;
   localparam int unsigned AXES              = 3;
   localparam int unsigned AX_W              = $clog2(AXES);
   localparam int unsigned VAL_W             = 32;
   localparam int unsigned SUM_W             = VAL_W + 2;
   localparam int unsigned CUT_W             = 17;
   localparam int unsigned DT_W              = 20;
   localparam int unsigned INST_W            = 2;
   localparam int unsigned ALPHA_W           = 16;
   localparam int unsigned NUM_W             = 64;
   localparam int unsigned CSR_IDX_W         = 1;

   // shared multiplier operand and product widths
   localparam int unsigned MUL_A_W = 34;
   localparam int unsigned MUL_B_W = 27;
   localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;
   // cutoff * dt product, split in a low word and a high remainder
   localparam int unsigned P1_W    = CUT_W + DT_W;
   localparam int unsigned SPLIT_W = 32;

   localparam int unsigned DIV_CNT_W = $clog2(ALPHA_W);

   // 2*pi in Q23, and 1.0 of the cutoff*dt scale (1e8 centihz*us) in Q23
   localparam int unsigned      TWO_PI_W       = 26;
   localparam logic [TWO_PI_W-1:0] TWO_PI_Q23  = 26'd52707179;
   localparam logic [NUM_W-1:0] UNIT_Q23       = 64'd838860800000000;
   localparam logic [CUT_W-1:0] DEFAULT_CUTOFF = 17'd500;

   localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GYRO_CUTOFF  = 1'b0,
      CSR_ACCEL_CUTOFF = 1'b1
   } csr_index_type;

   typedef enum logic {
      ACT_SAMPLE  = 1'b0,
      ACT_PUBLISH = 1'b1
   } action_type;

   typedef enum logic {
      KIND_GYRO  = 1'b0,
      KIND_ACCEL = 1'b1
   } kind_type;

   // state store bank select
   typedef enum logic {
      BANK_FILT = 1'b0,
      BANK_PUB  = 1'b1
   } bank_type;

   typedef struct packed {
      logic     rd_en;
      logic     wr_en;
      bank_type bank;
   } mem_ctl_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL_CD,
      S_MUL_HI,
      S_MUL_LO,
      S_SUM,
      S_DIV_GO,
      S_DIV,
      S_AX_RD,
      S_AX_MUL,
      S_AX_WR,
      S_CP_RD,
      S_CP_WR,
      S_PUB_RD,
      S_PUB_CAP,
      S_DONE
   } state_type;

endpackage

// File: hw/rtl/imu_vector_lowpass_filter.sv
// ----------------------------------------------------------------------------
// imu_vector_lowpass_filter
// One request at a time: req_stall holds off the next request until the response is loaded;
// an out-of-range instance goes straight to its response. A sample runs the 16-step alpha divider
// plus six shared-multiplier passes. Sync reset clears cutoffs, fresh flags, store valid bits.
// ----------------------------------------------------------------------------
`include "imu_vector_lowpass_filter_defines.svh"

module imu_vector_lowpass_filter #(
   parameter int unsigned NUM_INSTANCES = imuvlf_pkg::NUM_INSTANCES_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // configuration
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [imuvlf_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [imuvlf_pkg::CUT_W-1:0]            csr_wdata,
   // request
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_action,
   input  logic                                    req_sensor_kind,
   input  logic [imuvlf_pkg::INST_W-1:0]           req_instance_req,
   input  logic signed [imuvlf_pkg::VAL_W-1:0]     req_raw_x,
   input  logic signed [imuvlf_pkg::VAL_W-1:0]     req_raw_y,
   input  logic signed [imuvlf_pkg::VAL_W-1:0]     req_raw_z,
   input  logic [imuvlf_pkg::DT_W-1:0]             req_dt_us,
   // response
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [imuvlf_pkg::VAL_W-1:0]     rsp_out_x,
   output logic signed [imuvlf_pkg::VAL_W-1:0]     rsp_out_y,
   output logic signed [imuvlf_pkg::VAL_W-1:0]     rsp_out_z,
   output logic                                    rsp_fresh
);

   localparam int unsigned AXES    = imuvlf_pkg::AXES;
   localparam int unsigned AX_W    = imuvlf_pkg::AX_W;
   localparam int unsigned VAL_W   = imuvlf_pkg::VAL_W;
   localparam int unsigned SUM_W   = imuvlf_pkg::SUM_W;
   localparam int unsigned CUT_W   = imuvlf_pkg::CUT_W;
   localparam int unsigned DT_W    = imuvlf_pkg::DT_W;
   localparam int unsigned ALPHA_W = imuvlf_pkg::ALPHA_W;
   localparam int unsigned NUM_W   = imuvlf_pkg::NUM_W;
   localparam int unsigned MUL_A_W = imuvlf_pkg::MUL_A_W;
   localparam int unsigned MUL_B_W = imuvlf_pkg::MUL_B_W;
   localparam int unsigned MUL_P_W = imuvlf_pkg::MUL_P_W;
   localparam int unsigned P1_W    = imuvlf_pkg::P1_W;
   localparam int unsigned SPLIT_W = imuvlf_pkg::SPLIT_W;
   localparam int unsigned ROWS    = 2 * NUM_INSTANCES;
   localparam int unsigned ROW_W   = $clog2(ROWS);
   localparam int unsigned DEPTH   = ROWS * AXES;
   localparam int unsigned ADDR_W  = $clog2(DEPTH);

   localparam logic [ROW_W-1:0] N_ROW   = ROW_W'(NUM_INSTANCES);
   localparam logic [AX_W-1:0]  AX_LAST = AX_W'(AXES - 1);
   localparam logic signed [MUL_B_W-1:0] TWO_PI_OP =
      $signed(MUL_B_W'(imuvlf_pkg::TWO_PI_Q23));

   imuvlf_pkg::state_type state_ff, state_in;

   logic [AX_W-1:0]         ax_ff, ax_in;
   logic                    action_ff, action_in;
   logic                    kind_ff, kind_in;
   logic                    oor_ff, oor_in;
   logic [ROW_W-1:0]        row_ff, row_in;
   logic signed [VAL_W-1:0] raw_ff [AXES];
   logic signed [VAL_W-1:0] raw_in [AXES];
   logic [DT_W-1:0]         dt_ff, dt_in;
   logic [SPLIT_W-1:0]      p1lo_ff, p1lo_in;
   logic [NUM_W-1:0]        num_ff, num_in;
   logic signed [VAL_W-1:0] res_ff [AXES];
   logic signed [VAL_W-1:0] res_in [AXES];
   logic [ROWS-1:0]         fresh_ff, fresh_in;
   logic [CUT_W-1:0]        gyro_cut_ff, gyro_cut_in;
   logic [CUT_W-1:0]        accel_cut_ff, accel_cut_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [VAL_W-1:0] rsp_x_ff, rsp_x_in;
   logic signed [VAL_W-1:0] rsp_y_ff, rsp_y_in;
   logic signed [VAL_W-1:0] rsp_z_ff, rsp_z_in;
   logic                    rsp_fresh_ff, rsp_fresh_in;

   logic                    req_accept;
   logic                    rsp_load;
   logic [ROW_W-1:0]        req_row;
   logic                    req_oor;
   logic [CUT_W-1:0]        cut_sel, cut_eff;
   logic signed [VAL_W-1:0] raw_cur;
   logic signed [VAL_W:0]   diff;
   logic signed [SUM_W-1:0] delta, sum;
   logic signed [VAL_W-1:0] sat;

   imuvlf_pkg::mem_ctl_type      mem_ctl;
   logic [ADDR_W-1:0]            mem_addr;
   logic signed [VAL_W-1:0]      mem_wdata;
   logic signed [VAL_W-1:0]      mem_rd;
   logic signed [MUL_A_W-1:0]    mul_a;
   logic signed [MUL_B_W-1:0]    mul_b;
   logic signed [MUL_P_W-1:0]    mul_p;
   logic                         div_start;
   logic                         div_busy;
   logic [ALPHA_W-1:0]           div_quot;

   // handshakes
   assign csr_ready  = 1'b1;
   assign req_stall  = (state_ff != imuvlf_pkg::S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_load   = (state_ff == imuvlf_pkg::S_DONE) && (!rsp_valid_ff || !rsp_stall);

   // request decode
   assign req_oor = (32'(req_instance_req) >= NUM_INSTANCES);
   assign req_row = (req_sensor_kind == imuvlf_pkg::KIND_ACCEL) ?
                    (N_ROW + ROW_W'(req_instance_req)) : ROW_W'(req_instance_req);

   assign mem_addr = ADDR_W'(row_ff * AXES) + ADDR_W'(ax_ff);

   // shared units
   imuvlf_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_p)
   );

   imuvlf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff),
      .busy  (div_busy),
      .quot  (div_quot)
   );

   imuvlf_mem #(
      .NUM_INSTANCES (NUM_INSTANCES)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mem_ctl),
      .addr    (mem_addr),
      .wr_data (mem_wdata),
      .rd_data (mem_rd)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         imuvlf_pkg::S_IDLE: begin
            if (req_accept) begin
               if (req_oor) begin
                  state_in = imuvlf_pkg::S_DONE;
               end else if (req_action == imuvlf_pkg::ACT_SAMPLE) begin
                  state_in = imuvlf_pkg::S_MUL_CD;
               end else if (fresh_ff[req_row]) begin
                  state_in = imuvlf_pkg::S_CP_RD;
               end else begin
                  state_in = imuvlf_pkg::S_PUB_RD;
               end
            end
         end
         imuvlf_pkg::S_MUL_CD:  state_in = imuvlf_pkg::S_MUL_HI;
         imuvlf_pkg::S_MUL_HI:  state_in = imuvlf_pkg::S_MUL_LO;
         imuvlf_pkg::S_MUL_LO:  state_in = imuvlf_pkg::S_SUM;
         imuvlf_pkg::S_SUM:     state_in = imuvlf_pkg::S_DIV_GO;
         imuvlf_pkg::S_DIV_GO:  state_in = imuvlf_pkg::S_DIV;
         imuvlf_pkg::S_DIV: begin
            if (!div_busy) begin
               state_in = imuvlf_pkg::S_AX_RD;
            end
         end
         imuvlf_pkg::S_AX_RD:   state_in = imuvlf_pkg::S_AX_MUL;
         imuvlf_pkg::S_AX_MUL:  state_in = imuvlf_pkg::S_AX_WR;
         imuvlf_pkg::S_AX_WR: begin
            state_in = (ax_ff == AX_LAST) ? imuvlf_pkg::S_PUB_RD : imuvlf_pkg::S_AX_RD;
         end
         imuvlf_pkg::S_CP_RD:   state_in = imuvlf_pkg::S_CP_WR;
         imuvlf_pkg::S_CP_WR: begin
            state_in = (ax_ff == AX_LAST) ? imuvlf_pkg::S_PUB_RD : imuvlf_pkg::S_CP_RD;
         end
         imuvlf_pkg::S_PUB_RD:  state_in = imuvlf_pkg::S_PUB_CAP;
         imuvlf_pkg::S_PUB_CAP: begin
            state_in = (ax_ff == AX_LAST) ? imuvlf_pkg::S_DONE : imuvlf_pkg::S_PUB_RD;
         end
         imuvlf_pkg::S_DONE: begin
            if (rsp_load) begin
               state_in = imuvlf_pkg::S_IDLE;
            end
         end
         default: state_in = imuvlf_pkg::S_IDLE;
      endcase
   end

   // effective cutoff, zero means the default
   assign cut_sel = (kind_ff == imuvlf_pkg::KIND_ACCEL) ? accel_cut_ff : gyro_cut_ff;
   assign cut_eff = (cut_sel == '0) ? imuvlf_pkg::DEFAULT_CUTOFF : cut_sel;

   // axis blend: diff feeds the multiplier, product floors by 2^16
   assign raw_cur = raw_ff[ax_ff];
   assign diff    = {raw_cur[VAL_W-1], raw_cur} - {mem_rd[VAL_W-1], mem_rd};
   assign delta   = mul_p[ALPHA_W+SUM_W-1:ALPHA_W];
   assign sum     = $signed({{2{mem_rd[VAL_W-1]}}, mem_rd}) + delta;

   // saturate to 32 bit signed
   always_comb begin
      if (!sum[SUM_W-1] && (sum[SUM_W-2:VAL_W-1] != 2'b00)) begin
         sat = imuvlf_pkg::VAL_MAX;
      end else if (sum[SUM_W-1] && (sum[SUM_W-2:VAL_W-1] != 2'b11)) begin
         sat = imuvlf_pkg::VAL_MIN;
      end else begin
         sat = sum[VAL_W-1:0];
      end
   end

   // sequencer outputs: memory, multiplier operands, divider start
   always_comb begin
      mem_ctl   = '{rd_en: 1'b0, wr_en: 1'b0, bank: imuvlf_pkg::BANK_FILT};
      mem_wdata = sat;
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      unique case (state_ff)
         imuvlf_pkg::S_MUL_CD: begin
            mul_a = $signed(MUL_A_W'(dt_ff));
            mul_b = $signed(MUL_B_W'(cut_eff));
         end
         imuvlf_pkg::S_MUL_HI: begin
            mul_a = $signed(MUL_A_W'(mul_p[P1_W-1:SPLIT_W]));
            mul_b = TWO_PI_OP;
         end
         imuvlf_pkg::S_MUL_LO: begin
            mul_a = $signed(MUL_A_W'(p1lo_ff));
            mul_b = TWO_PI_OP;
         end
         imuvlf_pkg::S_DIV_GO: begin
            div_start = 1'b1;
         end
         imuvlf_pkg::S_AX_RD, imuvlf_pkg::S_CP_RD: begin
            mem_ctl.rd_en = 1'b1;
            mem_ctl.bank  = imuvlf_pkg::BANK_FILT;
         end
         imuvlf_pkg::S_AX_MUL: begin
            mul_a = MUL_A_W'(diff);
            mul_b = $signed(MUL_B_W'(div_quot));
         end
         imuvlf_pkg::S_AX_WR: begin
            mem_ctl.wr_en = 1'b1;
            mem_ctl.bank  = imuvlf_pkg::BANK_FILT;
            mem_wdata     = sat;
         end
         imuvlf_pkg::S_CP_WR: begin
            mem_ctl.wr_en = 1'b1;
            mem_ctl.bank  = imuvlf_pkg::BANK_PUB;
            mem_wdata     = mem_rd;
         end
         imuvlf_pkg::S_PUB_RD: begin
            mem_ctl.rd_en = 1'b1;
            mem_ctl.bank  = imuvlf_pkg::BANK_PUB;
         end
         default: begin
            mem_ctl = '{rd_en: 1'b0, wr_en: 1'b0, bank: imuvlf_pkg::BANK_FILT};
         end
      endcase
   end

   // datapath and flag next values
   always_comb begin
      ax_in        = ax_ff;
      action_in    = action_ff;
      kind_in      = kind_ff;
      oor_in       = oor_ff;
      row_in       = row_ff;
      raw_in       = raw_ff;
      dt_in        = dt_ff;
      p1lo_in      = p1lo_ff;
      num_in       = num_ff;
      res_in       = res_ff;
      fresh_in     = fresh_ff;
      gyro_cut_in  = gyro_cut_ff;
      accel_cut_in = accel_cut_ff;

      // configuration writes
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            imuvlf_pkg::CSR_GYRO_CUTOFF:  gyro_cut_in  = csr_wdata;
            imuvlf_pkg::CSR_ACCEL_CUTOFF: accel_cut_in = csr_wdata;
         endcase
      end

      unique case (state_ff)
         imuvlf_pkg::S_IDLE: begin
            if (req_accept) begin
               ax_in     = '0;
               action_in = req_action;
               kind_in   = req_sensor_kind;
               oor_in    = req_oor;
               row_in    = req_row;
               raw_in[0] = req_raw_x;
               raw_in[1] = req_raw_y;
               raw_in[2] = req_raw_z;
               dt_in     = req_dt_us;
               for (int a = 0; a < AXES; a++) begin
                  res_in[a] = '0;
               end
            end
         end
         imuvlf_pkg::S_MUL_HI: begin
            p1lo_in = mul_p[SPLIT_W-1:0];
         end
         imuvlf_pkg::S_MUL_LO: begin
            num_in = {mul_p[SPLIT_W-1:0], {SPLIT_W{1'b0}}};
         end
         imuvlf_pkg::S_SUM: begin
            num_in = num_ff + {{(NUM_W-MUL_P_W){1'b0}}, mul_p};
         end
         imuvlf_pkg::S_AX_WR: begin
            ax_in = (ax_ff == AX_LAST) ? '0 : ax_ff + AX_W'(1);
            if (ax_ff == AX_LAST) begin
               fresh_in[row_ff] = 1'b1;
            end
         end
         imuvlf_pkg::S_CP_WR: begin
            ax_in = (ax_ff == AX_LAST) ? '0 : ax_ff + AX_W'(1);
            if (ax_ff == AX_LAST) begin
               fresh_in[row_ff] = 1'b0;
            end
         end
         imuvlf_pkg::S_PUB_CAP: begin
            res_in[ax_ff] = mem_rd;
            ax_in         = (ax_ff == AX_LAST) ? '0 : ax_ff + AX_W'(1);
         end
         default: begin
            ax_in = ax_ff;
         end
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_z_in     = rsp_z_ff;
      rsp_fresh_in = rsp_fresh_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_x_in     = res_ff[0];
         rsp_y_in     = res_ff[1];
         rsp_z_in     = res_ff[2];
         rsp_fresh_in = oor_ff ? 1'b0 : fresh_ff[row_ff];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= imuvlf_pkg::S_IDLE;
         fresh_ff     <= '0;
         gyro_cut_ff  <= '0;
         accel_cut_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fresh_ff     <= fresh_in;
         gyro_cut_ff  <= gyro_cut_in;
         accel_cut_ff <= accel_cut_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ax_ff        <= ax_in;
      action_ff    <= action_in;
      kind_ff      <= kind_in;
      oor_ff       <= oor_in;
      row_ff       <= row_in;
      raw_ff       <= raw_in;
      dt_ff        <= dt_in;
      p1lo_ff      <= p1lo_in;
      num_ff       <= num_in;
      res_ff       <= res_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_z_ff     <= rsp_z_in;
      rsp_fresh_ff <= rsp_fresh_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_x = rsp_x_ff;
   assign rsp_out_y = rsp_y_ff;
   assign rsp_out_z = rsp_z_ff;
   assign rsp_fresh = rsp_fresh_ff;

   // checks
   `IMUVLF_ASSERT_NEXT(a_fresh_after_sample,
      (state_ff == imuvlf_pkg::S_AX_WR) && (ax_ff == AX_LAST),
      fresh_ff[row_ff], "fresh flag not set after last axis of a sample")
   `IMUVLF_ASSERT_NEXT(a_rsp_fresh_follows_action,
      rsp_load && !oor_ff,
      rsp_fresh == ($past(action_ff) == imuvlf_pkg::ACT_SAMPLE),
      "response fresh flag does not match the transaction type")
   `IMUVLF_ASSERT_NEXT(a_oor_rsp_zero,
      rsp_load && oor_ff,
      (rsp_out_x == '0) && (rsp_out_y == '0) && (rsp_out_z == '0) && !rsp_fresh,
      "out-of-range instance did not return a zero response")

endmodule

// File: hw/rtl/imuvlf_mul.sv
// ----------------------------------------------------------------------------
// imuvlf_mul
// Shared signed multiplier with a registered product, used for the cutoff*dt
// scaling passes and for the per-axis alpha blend.
// ----------------------------------------------------------------------------
module imuvlf_mul (
   input  logic                                      clock,
   input  logic signed [imuvlf_pkg::MUL_A_W-1:0]     op_a,
   input  logic signed [imuvlf_pkg::MUL_B_W-1:0]     op_b,
   output logic signed [imuvlf_pkg::MUL_P_W-1:0]     prod
);

   logic signed [imuvlf_pkg::MUL_P_W-1:0] prod_ff;
   logic signed [imuvlf_pkg::MUL_P_W-1:0] prod_in;

   // full-width signed product
   always_comb begin
      prod_in = imuvlf_pkg::MUL_P_W'(op_a) * imuvlf_pkg::MUL_P_W'(op_b);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// File: hw/rtl/imuvlf_div.sv
// ----------------------------------------------------------------------------
// imuvlf_div
// Restoring divider for alpha = num / (num + unit) as a Q0.16 fraction.
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
module imuvlf_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [imuvlf_pkg::NUM_W-1:0]        num,
   output logic                                busy,
   output logic [imuvlf_pkg::ALPHA_W-1:0]      quot
);

   localparam int unsigned NUM_W     = imuvlf_pkg::NUM_W;
   localparam int unsigned ALPHA_W   = imuvlf_pkg::ALPHA_W;
   localparam int unsigned DIV_CNT_W = imuvlf_pkg::DIV_CNT_W;
   localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(ALPHA_W - 1);

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0]     rem_ff, rem_in;
   logic [NUM_W-1:0]     den_ff, den_in;
   logic [ALPHA_W-1:0]   quot_ff, quot_in;
   logic [NUM_W-1:0]     rem_sh;
   logic                 fits;

   // remainder stays below 2^63, so the shift never drops a bit
   always_comb begin
      rem_sh  = {rem_ff[NUM_W-2:0], 1'b0};
      fits    = (rem_sh >= den_ff);
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = num;
         den_in  = num + imuvlf_pkg::UNIT_Q23;
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? (rem_sh - den_ff) : rem_sh;
         quot_in = {quot_ff[ALPHA_W-2:0], fits};
         cnt_in  = cnt_ff + DIV_CNT_W'(1);
         busy_in = (cnt_ff != CNT_LAST);
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign busy = busy_ff;
   assign quot = quot_ff;

endmodule

// File: hw/rtl/imuvlf_mem.sv
// ----------------------------------------------------------------------------
// imuvlf_mem
// Filtered and published vector store, one entry per kind, instance and axis.
// Single access per cycle, registered read, per-entry valid bits so that an
// entry not yet written reads as zero.
// ----------------------------------------------------------------------------
module imuvlf_mem #(
   parameter int unsigned  NUM_INSTANCES = imuvlf_pkg::NUM_INSTANCES_DEF,
   localparam int unsigned DEPTH         = 2 * NUM_INSTANCES * imuvlf_pkg::AXES,
   localparam int unsigned ADDR_W        = $clog2(DEPTH)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  imuvlf_pkg::mem_ctl_type               ctl,
   input  logic [ADDR_W-1:0]                     addr,
   input  logic signed [imuvlf_pkg::VAL_W-1:0]   wr_data,
   output logic signed [imuvlf_pkg::VAL_W-1:0]   rd_data
);

   localparam int unsigned VAL_W = imuvlf_pkg::VAL_W;

   logic signed [VAL_W-1:0] filt_mem_ff [DEPTH];
   logic signed [VAL_W-1:0] pub_mem_ff  [DEPTH];
   logic [DEPTH-1:0]        filt_vld_ff, filt_vld_in;
   logic [DEPTH-1:0]        pub_vld_ff, pub_vld_in;
   logic signed [VAL_W-1:0] rd_ff;
   logic                    rd_vld_ff;
   logic                    wr_filt, wr_pub;

   assign wr_filt = ctl.wr_en && (ctl.bank == imuvlf_pkg::BANK_FILT);
   assign wr_pub  = ctl.wr_en && (ctl.bank == imuvlf_pkg::BANK_PUB);

   // valid bits follow writes
   always_comb begin
      filt_vld_in = filt_vld_ff;
      pub_vld_in  = pub_vld_ff;
      if (wr_filt) begin
         filt_vld_in[addr] = 1'b1;
      end
      if (wr_pub) begin
         pub_vld_in[addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filt_vld_ff <= '0;
         pub_vld_ff  <= '0;
      end else begin
         filt_vld_ff <= filt_vld_in;
         pub_vld_ff  <= pub_vld_in;
      end
   end

   // array writes
   always_ff @(posedge clock) begin
      if (wr_filt) begin
         filt_mem_ff[addr] <= wr_data;
      end
      if (wr_pub) begin
         pub_mem_ff[addr] <= wr_data;
      end
   end

   // registered read, held until the next read
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         if (ctl.bank == imuvlf_pkg::BANK_PUB) begin
            rd_ff     <= pub_mem_ff[addr];
            rd_vld_ff <= pub_vld_ff[addr];
         end else begin
            rd_ff     <= filt_mem_ff[addr];
            rd_vld_ff <= filt_vld_ff[addr];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_ff : '0;

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// IMU vector low-pass filter testbench
// Drives sample and publish transactions into the filter under random sender
// gaps and receiver stalls. A local predictor tracks the filtered, published
// and fresh state of every sensor bank. Each response is compared field by
// field against the oldest predicted vector. Cutoff registers are changed
// between phases once the block has drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned  NUM_INST       = imuvlf_pkg::NUM_INSTANCES_DEF;
   localparam int unsigned  RESET_CYCLES   = 12;
   localparam int unsigned  HOLD_CYCLES    = 400;
   localparam int unsigned  WATCHDOG_LIMIT = 4000;
   localparam int unsigned  DRAIN_CYCLES   = 60;
   localparam int unsigned  MAX_CUTOFF     = 100000;
   localparam int unsigned  MAX_DT         = 1000000;
   // 2*pi and the 1e8 centihz*us unit, both in Q23
   localparam logic [65:0]  TWO_PI_FIX     = 66'd52707179;
   localparam logic [65:0]  UNIT_FIX       = 66'd838860800000000;
   localparam logic [16:0]  FALLBACK_CUT   = 17'd500;

   typedef struct {
      imuvlf_pkg::action_type action;
      imuvlf_pkg::kind_type   kind;
      logic [1:0]             inst;
      logic signed [31:0]     raw_x;
      logic signed [31:0]     raw_y;
      logic signed [31:0]     raw_z;
      logic [19:0]            dt;
   } filter_req_type;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic               fresh;
   } imu_vector_type;

   // DUT connections
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [0:0]         csr_index = '0;
   logic [16:0]        csr_wdata = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_action = 1'b0;
   logic               req_sensor_kind = 1'b0;
   logic [1:0]         req_instance_req = '0;
   logic signed [31:0] req_raw_x = '0;
   logic signed [31:0] req_raw_y = '0;
   logic signed [31:0] req_raw_z = '0;
   logic [19:0]        req_dt_us = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_out_x;
   logic signed [31:0] rsp_out_y;
   logic signed [31:0] rsp_out_z;
   logic               rsp_fresh;

   // predictor state
   logic signed [31:0] filt_vec [2][NUM_INST][3];
   logic signed [31:0] pub_vec  [2][NUM_INST][3];
   logic               fresh_bit [2][NUM_INST];
   logic [16:0]        gyro_cut;
   logic [16:0]        accel_cut;

   imu_vector_type     expected_vectors [$];
   int                 error_count = 0;
   int                 burst_left = 0;
   int                 idle_cycles = 0;
   int                 stall_cycle = 0;
   int                 hold_left = 0;
   int                 hold_requests = 0;
   int                 hold_served = 0;

   imu_vector_lowpass_filter uut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_sensor_kind  (req_sensor_kind),
      .req_instance_req (req_instance_req),
      .req_raw_x        (req_raw_x),
      .req_raw_y        (req_raw_y),
      .req_raw_z        (req_raw_z),
      .req_dt_us        (req_dt_us),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y),
      .rsp_out_z        (rsp_out_z),
      .rsp_fresh        (rsp_fresh)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------

   // alpha = floor(65536 * w / (1 + w)) by restoring division
   function automatic logic [15:0] filter_alpha(input logic [16:0] cutoff,
                                                input logic [19:0] dt);
      logic [16:0] cut;
      logic [65:0] num;
      logic [65:0] den;
      logic [65:0] rem;
      logic [15:0] quo;
      cut = (cutoff == '0) ? FALLBACK_CUT : cutoff;
      num = 66'(cut) * 66'(dt) * TWO_PI_FIX;
      den = num + UNIT_FIX;
      rem = num;
      quo = '0;
      for (int i = 0; i < 16; i++) begin
         rem = rem << 1;
         quo = quo << 1;
         if (rem >= den) begin
            rem = rem - den;
            quo[0] = 1'b1;
         end
      end
      return quo;
   endfunction

   // one axis moves toward raw by alpha, floor rounding, saturated
   function automatic logic signed [31:0] smooth_axis(input logic signed [31:0] cur,
                                                      input logic signed [31:0] raw,
                                                      input logic [15:0] alpha);
      logic signed [33:0] diff;
      logic signed [50:0] prod;
      logic signed [51:0] sum;
      diff = 34'(raw) - 34'(cur);
      prod = diff * $signed({1'b0, alpha});
      sum  = 52'(cur) + 52'(prod >>> 16);
      if (sum > 52'sd2147483647)
         sum = 52'sd2147483647;
      if (sum < -52'sd2147483648)
         sum = -52'sd2147483648;
      return sum[31:0];
   endfunction

   function automatic imu_vector_type predict_filter_response(input filter_req_type r);
      imu_vector_type v;
      logic [15:0] alpha;
      int k;
      int n;
      v = '{x: '0, y: '0, z: '0, fresh: 1'b0};
      if (r.inst >= NUM_INST)
         return v;
      k = int'(r.kind);
      n = int'(r.inst);
      if (r.action == imuvlf_pkg::ACT_SAMPLE) begin
         alpha = filter_alpha((r.kind == imuvlf_pkg::KIND_ACCEL) ? accel_cut : gyro_cut,
                              r.dt);
         filt_vec[k][n][0] = smooth_axis(filt_vec[k][n][0], r.raw_x, alpha);
         filt_vec[k][n][1] = smooth_axis(filt_vec[k][n][1], r.raw_y, alpha);
         filt_vec[k][n][2] = smooth_axis(filt_vec[k][n][2], r.raw_z, alpha);
         fresh_bit[k][n] = 1'b1;
      end else if (fresh_bit[k][n]) begin
         for (int a = 0; a < 3; a++)
            pub_vec[k][n][a] = filt_vec[k][n][a];
         fresh_bit[k][n] = 1'b0;
      end
      v.x = pub_vec[k][n][0];
      v.y = pub_vec[k][n][1];
      v.z = pub_vec[k][n][2];
      v.fresh = fresh_bit[k][n];
      return v;
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------

   task automatic report_error(input string msg);
      $display("ERROR %0t: %s", $time, msg);
      error_count++;
   endtask

   // one request transaction; sender gaps fall between bursts
   task automatic send_request(input filter_req_type r);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_action       <= r.action;
      req_sensor_kind  <= r.kind;
      req_instance_req <= r.inst;
      req_raw_x        <= r.raw_x;
      req_raw_y        <= r.raw_y;
      req_raw_z        <= r.raw_z;
      req_dt_us        <= r.dt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_vectors.push_back(predict_filter_response(r));
   endtask

   task automatic send_item(input imuvlf_pkg::action_type act,
                            input imuvlf_pkg::kind_type kind,
                            input logic [1:0] inst, input logic signed [31:0] x,
                            input logic signed [31:0] y, input logic signed [31:0] z,
                            input logic [19:0] dt);
      filter_req_type r;
      r = '{action: act, kind: kind, inst: inst, raw_x: x, raw_y: y, raw_z: z, dt: dt};
      send_request(r);
   endtask

   // stop offering and let every outstanding response come back
   task automatic drain_block();
      req_valid <= 1'b0;
      burst_left = 0;
      while (expected_vectors.size() != 0) @(posedge clock);
   endtask

   // both cutoffs written back to back while the block is idle
   task automatic write_cutoffs(input logic [16:0] gyro, input logic [16:0] accel);
      drain_block();
      csr_valid <= 1'b1;
      csr_index <= imuvlf_pkg::CSR_GYRO_CUTOFF;
      csr_wdata <= gyro;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      gyro_cut = gyro;
      csr_index <= imuvlf_pkg::CSR_ACCEL_CUTOFF;
      csr_wdata <= accel;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      accel_cut = accel;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [31:0] pick_raw();
      case ($urandom_range(0, 7))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2, 3:    return $urandom;
         default: return 32'($signed($urandom_range(0, 2 * (1 << 22)))) - (1 << 22);
      endcase
   endfunction

   function automatic logic [19:0] pick_dt();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return 20'(MAX_DT);
         2, 3:    return 20'($urandom_range(0, MAX_DT));
         4, 5:    return 20'($urandom_range(2000, 50000));
         default: return 20'($urandom_range(1, 2000));
      endcase
   endfunction

   function automatic filter_req_type pick_request();
      filter_req_type r;
      r.action = ($urandom_range(0, 9) < 6) ? imuvlf_pkg::ACT_SAMPLE
                                            : imuvlf_pkg::ACT_PUBLISH;
      r.kind   = imuvlf_pkg::kind_type'($urandom_range(0, 1));
      r.inst   = ($urandom_range(0, 11) == 0) ? 2'd3 : 2'($urandom_range(0, NUM_INST - 1));
      r.raw_x  = pick_raw();
      r.raw_y  = pick_raw();
      r.raw_z  = pick_raw();
      r.dt     = pick_dt();
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // reset cutoffs act as 5 Hz; publish paths, zero dt, out-of-range bank
   task automatic test_default_cutoff();
      send_item(imuvlf_pkg::ACT_PUBLISH, imuvlf_pkg::KIND_GYRO, 2'd0, 0, 0, 0, 20'd0);
      send_item(imuvlf_pkg::ACT_SAMPLE, imuvlf_pkg::KIND_GYRO, 2'd0, 32'sh7FFF_FFFF,
                32'sh8000_0000, 0, 20'(MAX_DT));
      send_item(imuvlf_pkg::ACT_PUBLISH, imuvlf_pkg::KIND_GYRO, 2'd0, 0, 0, 0, 20'd0);
      send_item(imuvlf_pkg::ACT_PUBLISH, imuvlf_pkg::KIND_GYRO, 2'd0, 0, 0, 0, 20'd0);
      send_item(imuvlf_pkg::ACT_SAMPLE, imuvlf_pkg::KIND_ACCEL, 2'd2, 32'sh8000_0000,
                32'sh7FFF_FFFF, -1, 20'(MAX_DT));
      send_item(imuvlf_pkg::ACT_SAMPLE, imuvlf_pkg::KIND_ACCEL, 2'd2, 32'sh7FFF_FFFF, 0,
                32'sh8000_0000, 20'd0);
      send_item(imuvlf_pkg::ACT_PUBLISH, imuvlf_pkg::KIND_ACCEL, 2'd2, 0, 0, 0, 20'hFFFFF);
      send_item(imuvlf_pkg::ACT_SAMPLE, imuvlf_pkg::KIND_GYRO, 2'd1, 32'sh7FFF_FFFF,
                32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 20'd1);
      send_item(imuvlf_pkg::ACT_SAMPLE, imuvlf_pkg::KIND_GYRO, 2'd3, 32'sh1234_5678, -5, 7,
                20'd1000);
      send_item(imuvlf_pkg::ACT_PUBLISH, imuvlf_pkg::KIND_ACCEL, 2'd3, 0, 0, 0, 20'd0);
      send_item(imuvlf_pkg::ACT_PUBLISH, imuvlf_pkg::KIND_GYRO, 2'd1, 0, 0, 0, 20'd0);
   endtask

   // largest cutoff saturates alpha, smallest nearly stops the filter
   task automatic test_extreme_cutoffs();
      write_cutoffs(17'(MAX_CUTOFF), 17'(MAX_CUTOFF));
      send_item(imuvlf_pkg::ACT_SAMPLE, imuvlf_pkg::KIND_GYRO, 2'd0, 32'sh7FFF_FFFF,
                32'sh7FFF_FFFF, 32'sh8000_0000, 20'(MAX_DT));
      send_item(imuvlf_pkg::ACT_SAMPLE, imuvlf_pkg::KIND_GYRO, 2'd0, 32'sh8000_0000,
                32'sh8000_0000, 32'sh7FFF_FFFF, 20'(MAX_DT));
      send_item(imuvlf_pkg::ACT_PUBLISH, imuvlf_pkg::KIND_GYRO, 2'd0, 0, 0, 0, 20'd0);
      send_item(imuvlf_pkg::ACT_SAMPLE, imuvlf_pkg::KIND_ACCEL, 2'd1, 32'sh7FFF_FFFF,
                -32'sd65536, 32'sd65536, 20'd1);
      send_item(imuvlf_pkg::ACT_PUBLISH, imuvlf_pkg::KIND_ACCEL, 2'd1, 0, 0, 0, 20'd0);
      write_cutoffs(17'd1, 17'd1);
      send_item(imuvlf_pkg::ACT_SAMPLE, imuvlf_pkg::KIND_GYRO, 2'd2, 32'sh8000_0000,
                32'sh7FFF_FFFF, 0, 20'(MAX_DT));
      send_item(imuvlf_pkg::ACT_SAMPLE, imuvlf_pkg::KIND_ACCEL, 2'd0, 32'sh7FFF_FFFF,
                32'sh8000_0000, 1, 20'(MAX_DT));
      send_item(imuvlf_pkg::ACT_PUBLISH, imuvlf_pkg::KIND_GYRO, 2'd2, 0, 0, 0, 20'd0);
      send_item(imuvlf_pkg::ACT_PUBLISH, imuvlf_pkg::KIND_ACCEL, 2'd0, 0, 0, 0, 20'd0);
   endtask

   // random traffic under a series of cutoff settings
   task automatic test_random_traffic();
      logic [16:0] gyro_set [5];
      logic [16:0] accel_set [5];
      gyro_set  = '{17'($urandom_range(0, MAX_CUTOFF)), 17'd0, 17'(MAX_CUTOFF), 17'd1,
                    17'($urandom_range(0, 3000))};
      accel_set = '{17'($urandom_range(0, MAX_CUTOFF)), 17'(MAX_CUTOFF), 17'd1, 17'd0,
                    17'($urandom_range(0, MAX_CUTOFF))};
      for (int p = 0; p < 5; p++) begin
         write_cutoffs(gyro_set[p], accel_set[p]);
         repeat (120) send_request(pick_request());
      end
   endtask

   // receiver holds off long enough that the block backs up its input
   task automatic test_backpressure();
      write_cutoffs(17'($urandom_range(0, MAX_CUTOFF)), 17'($urandom_range(0, MAX_CUTOFF)));
      hold_requests <= hold_requests + 1;
      burst_left = 40;
      repeat (30) send_request(pick_request());
   endtask

   // ---------------------------------------------------------------------------
   // Receiver stall pattern, with a long hold-off on request
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      stall_cycle++;
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_cycle[7:6])
            2'd0: rsp_stall <= 1'b0;
            2'd1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2'd2: rsp_stall <= ($urandom_range(0, 3) != 0);
            2'd3: rsp_stall <= (stall_cycle[1:0] == 2'd0);
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // Response checker
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      imu_vector_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_vectors.size() == 0) begin
            report_error($sformatf("unexpected response x=%0d y=%0d z=%0d fresh=%0b",
                                   rsp_out_x, rsp_out_y, rsp_out_z, rsp_fresh));
         end else begin
            want = expected_vectors.pop_front();
            if (rsp_out_x !== want.x)
               report_error($sformatf("out_x got %0d want %0d", rsp_out_x, want.x));
            if (rsp_out_y !== want.y)
               report_error($sformatf("out_y got %0d want %0d", rsp_out_y, want.y));
            if (rsp_out_z !== want.z)
               report_error($sformatf("out_z got %0d want %0d", rsp_out_z, want.z));
            if (rsp_fresh !== want.fresh)
               report_error($sformatf("fresh got %0b want %0b", rsp_fresh, want.fresh));
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Watchdog: too long without any transaction
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("status: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin
      for (int k = 0; k < 2; k++)
         for (int n = 0; n < NUM_INST; n++) begin
            for (int a = 0; a < 3; a++) begin
               filt_vec[k][n][a] = '0;
               pub_vec[k][n][a]  = '0;
            end
            fresh_bit[k][n] = 1'b0;
         end
      gyro_cut  = '0;
      accel_cut = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_cutoff();
      test_extreme_cutoffs();
      test_random_traffic();
      test_backpressure();

      drain_block();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
